// File: hdl/drifting_quadrature_tone_generator_top_defines.svh
// Assertion helpers for the tone generator.
`ifndef DRIFTING_QUADRATURE_TONE_GENERATOR_TOP_DEFINES_SVH
`define DRIFTING_QUADRATURE_TONE_GENERATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle.
`define DQTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the next cycle.
`define DQTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dqtg_pkg.sv
package dqtg_pkg;

  localparam int unsigned DataW = 32;

  // register indexes
  localparam logic [2:0] CFG_PHASE_STEP   = 3'd0;
  localparam logic [2:0] CFG_DRIFT_FRAC   = 3'd1;
  localparam logic [2:0] CFG_NOISE_GAIN   = 3'd2;
  localparam logic [2:0] CFG_START_DETUNE = 3'd3;
  localparam logic [2:0] CFG_VOLUME       = 3'd4;

  // register reset values
  localparam logic [31:0]        PHASE_STEP_RST   = 32'd0;
  localparam logic [31:0]        DRIFT_FRAC_RST   = 32'd0;
  localparam logic signed [31:0] NOISE_GAIN_RST   = 32'sd0;
  localparam logic signed [31:0] START_DETUNE_RST = 32'sd16777216;
  localparam logic [31:0]        VOLUME_RST       = 32'd16777216;

  // oscillator state after reset (derived from the register reset values)
  localparam logic signed [31:0] VELOCITY_RST = 32'sd2684355;
  localparam logic [31:0]        SEED_INIT    = 32'd157898685;

  // multiplier constants, 33-bit signed operand form
  localparam logic signed [32:0] LCG_MULT  = 33'sd16807;
  localparam logic signed [32:0] K_001_Q32 = 33'sd42949673;
  localparam logic signed [32:0] K_099_Q30 = 33'sd1063004406;
  localparam logic signed [32:0] K_101_Q30 = 33'sd1084479242;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
    logic signed [31:0] res;
    if (x > 44'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (x < -44'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/drifting_quadrature_tone_generator_top.sv
// Each input beat runs the micro-op sequence, with the reload ops first when restart is set.
// Every step goes through one shared 33x33 multiplier (multiply, then
//   round/writeback); a new input beat is taken only while the sequencer is idle.
// A finished result waits in the output register while the next beat is taken.
// Reset (async, active low): registers to defaults, oscillator state to the
//   state those defaults derive, sequencer idle, no result pending.
`include "drifting_quadrature_tone_generator_top_defines.svh"

module drifting_quadrature_tone_generator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input beats
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             restart_i,
  input  logic                             mix_enable_i,
  input  logic signed [dqtg_pkg::DataW-1:0] mix_sample_i,
  // result beats
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [dqtg_pkg::DataW-1:0] sample_o,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [dqtg_pkg::DataW-1:0]       cfg_wdata_i
);
  import dqtg_pkg::*;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;  // shared multiplier fires
  localparam logic [1:0] ST_WB   = 2'd2;  // round, saturate, write state
  localparam logic [1:0] ST_DONE = 2'd3;  // hand sample to output register

  // Micro-ops, executed in this order. The first two only on restart.
  localparam logic [3:0] OP_VEL0  = 4'd0;   // velocity = volume * 0.01
  localparam logic [3:0] OP_FF0   = 4'd1;   // freq = phase_step * detune
  localparam logic [3:0] OP_DT    = 4'd2;   // drift term
  localparam logic [3:0] OP_RC    = 4'd3;   // noise_gain * drift
  localparam logic [3:0] OP_RCOEF = 4'd4;   // phase_step * rc
  localparam logic [3:0] OP_POS   = 4'd5;   // position += vel * ff
  localparam logic [3:0] OP_VEL   = 4'd6;   // velocity -= pos * ff, sample
  localparam logic [3:0] OP_SEED  = 4'd7;   // seed *= 16807, threshold compare
  localparam logic [3:0] OP_VSC   = 4'd8;   // velocity *= 0.99 or 1.01
  localparam logic [3:0] OP_E0    = 4'd9;   // energy leak
  localparam logic [3:0] OP_E1    = 4'd10;  // + pos^2
  localparam logic [3:0] OP_E2    = 4'd11;  // + vel^2
  localparam logic [3:0] OP_F0    = 4'd12;  // ff - ff*drift
  localparam logic [3:0] OP_F1    = 4'd13;  // + drift term + noise

  // configuration registers
  logic [31:0]        phase_step_q, drift_frac_q, volume_q;
  logic signed [31:0] noise_gain_q, start_detune_q;

  // oscillator state
  logic signed [31:0] pos_q, pos_d, vel_q, vel_d, ff_q, ff_d, energy_q, energy_d;
  logic [31:0]        seed_q, seed_d;

  // per-step scratch
  logic [26:0]        dterm_q, dterm_d;
  logic signed [31:0] rc_q, rc_d, rcoef_q, rcoef_d;
  logic signed [35:0] acc_q, acc_d;
  logic               gt_q, gt_d;
  logic signed [31:0] smp_q, smp_d;

  // captured input beat
  logic               restart_q, mix_en_q;
  logic signed [31:0] mix_q;

  // sequencer and output register
  logic [1:0]         state_q, state_d;
  logic [3:0]         op_q, op_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_q;

  // shared multiplier and rounder
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic [6:0]         shamt, rb_idx;
  logic signed [65:0] shifted;
  logic signed [41:0] rnd;

  logic               in_beat;
  logic [40:0]        thr;
  logic signed [40:0] energy_x256;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign sample_o    = out_q;

  // Operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      OP_VEL0: begin
        mul_a = $signed({1'b0, volume_q});
        mul_b = K_001_Q32;
      end
      OP_FF0: begin
        mul_a = $signed({1'b0, phase_step_q});
        mul_b = 33'(start_detune_q);
      end
      OP_DT: begin
        mul_a = $signed({1'b0, phase_step_q});
        mul_b = $signed({1'b0, drift_frac_q});
      end
      OP_RC: begin
        mul_a = 33'(noise_gain_q);
        mul_b = $signed({1'b0, drift_frac_q});
      end
      OP_RCOEF: begin
        mul_a = $signed({1'b0, phase_step_q});
        mul_b = 33'(rc_q);
      end
      OP_POS: begin
        mul_a = 33'(vel_q);
        mul_b = 33'(ff_q);
      end
      OP_VEL: begin
        mul_a = 33'(pos_q);
        mul_b = 33'(ff_q);
      end
      OP_SEED: begin
        mul_a = $signed({1'b0, seed_q});
        mul_b = LCG_MULT;
      end
      OP_VSC: begin
        mul_a = 33'(vel_q);
        mul_b = gt_q ? K_099_Q30 : K_101_Q30;
      end
      OP_E0: begin
        mul_a = 33'(energy_q);
        mul_b = K_099_Q30;
      end
      OP_E1: begin
        mul_a = 33'(pos_q);
        mul_b = 33'(pos_q);
      end
      OP_E2: begin
        mul_a = 33'(vel_q);
        mul_b = 33'(vel_q);
      end
      OP_F0: begin
        // negate before rounding: ties must round on -ff*drift itself
        mul_a = -33'(ff_q);
        mul_b = $signed({1'b0, drift_frac_q});
      end
      OP_F1: begin
        mul_a = $signed({1'b0, seed_q});
        mul_b = 33'(rcoef_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounding shift: floor plus the bit below (half rounds up)
  always_comb begin
    case (op_q)
      OP_VEL0:                 shamt = 7'd28;
      OP_FF0, OP_RCOEF, OP_VSC, OP_E0: shamt = 7'd30;
      OP_DT:                   shamt = 7'd38;
      OP_POS, OP_VEL:          shamt = 7'd24;
      default:                 shamt = 7'd32;
    endcase
  end

  assign rb_idx  = shamt - 7'd1;
  assign shifted = prod_q >>> shamt;
  assign rnd     = shifted[41:0] + $signed({41'd0, prod_q[rb_idx]});

  // energy in Q8.32 against rand0 + 0.5
  assign thr         = {9'd0, prod_q[31:0]} + 41'h0_8000_0000;
  assign energy_x256 = $signed({energy_q[31], energy_q, 8'h00});

  // Writeback
  always_comb begin
    pos_d    = pos_q;
    vel_d    = vel_q;
    ff_d     = ff_q;
    energy_d = energy_q;
    seed_d   = seed_q;
    dterm_d  = dterm_q;
    rc_d     = rc_q;
    rcoef_d  = rcoef_q;
    acc_d    = acc_q;
    gt_d     = gt_q;
    smp_d    = smp_q;
    if (state_q == ST_WB) begin
      case (op_q)
        OP_VEL0: begin
          vel_d    = sat32(44'(rnd));
          pos_d    = '0;
          energy_d = '0;
          seed_d   = SEED_INIT;
        end
        OP_FF0:   ff_d    = sat32(44'(rnd));
        OP_DT:    dterm_d = rnd[26:0];
        OP_RC:    rc_d    = sat32(44'(rnd));
        OP_RCOEF: rcoef_d = sat32(44'(rnd));
        OP_POS:   pos_d   = sat32(44'(pos_q) + 44'(rnd));
        OP_VEL: begin
          vel_d = sat32(44'(vel_q) - 44'(rnd));
          smp_d = mix_en_q ? sat32(44'(mix_q) + 44'(pos_q)) : pos_q;
        end
        OP_SEED: begin
          seed_d = prod_q[31:0];
          gt_d   = energy_x256 > $signed(thr);
        end
        OP_VSC:   vel_d    = sat32(44'(rnd));
        OP_E0:    acc_d    = rnd[35:0];
        OP_E1:    acc_d    = acc_q + rnd[35:0];
        OP_E2:    energy_d = sat32(44'(acc_q) + 44'(rnd));
        OP_F0:    acc_d    = 36'(ff_q) + rnd[35:0];
        OP_F1:    ff_d     = sat32(44'(acc_q) + 44'($signed({1'b0, dterm_q})) + 44'(rnd));
        default: begin
          acc_d = acc_q;
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = ST_MUL;
          op_d    = restart_i ? OP_VEL0 : OP_DT;
        end
      end
      ST_MUL: state_d = ST_WB;
      ST_WB: begin
        if (op_q == OP_F1) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
          op_d    = op_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= PHASE_STEP_RST;
      drift_frac_q   <= DRIFT_FRAC_RST;
      noise_gain_q   <= NOISE_GAIN_RST;
      start_detune_q <= START_DETUNE_RST;
      volume_q       <= VOLUME_RST;
      pos_q          <= '0;
      vel_q          <= VELOCITY_RST;
      ff_q           <= '0;
      energy_q       <= '0;
      seed_q         <= SEED_INIT;
      state_q        <= ST_IDLE;
      op_q           <= OP_DT;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PHASE_STEP:   phase_step_q   <= cfg_wdata_i;
          CFG_DRIFT_FRAC:   drift_frac_q   <= cfg_wdata_i;
          CFG_NOISE_GAIN:   noise_gain_q   <= $signed(cfg_wdata_i);
          CFG_START_DETUNE: start_detune_q <= $signed(cfg_wdata_i);
          CFG_VOLUME:       volume_q       <= cfg_wdata_i;
          default: begin
            phase_step_q <= phase_step_q;
          end
        endcase
      end
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      ff_q        <= ff_d;
      energy_q    <= energy_d;
      seed_q      <= seed_d;
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and scratch, no reset
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      restart_q <= restart_i;
      mix_en_q  <= mix_enable_i;
      mix_q     <= mix_sample_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_a * mul_b;
    end
    if ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) begin
      out_q <= smp_q;
    end
    dterm_q <= dterm_d;
    rc_q    <= rc_d;
    rcoef_q <= rcoef_d;
    acc_q   <= acc_d;
    gt_q    <= gt_d;
    smp_q   <= smp_d;
  end

  `DQTG_ASSERT_NEXT(a_busy_after_beat, in_beat, state_q == ST_MUL, "no busy after input beat")
  `DQTG_ASSERT_NEXT(a_restart_entry, in_beat && !restart_i, op_q == OP_DT, "bad entry op")
  `DQTG_ASSERT_NOW(a_restart_ops, (state_q != ST_IDLE) && (op_q == OP_VEL0 || op_q == OP_FF0), restart_q, "reload op without restart")
  `DQTG_ASSERT_NEXT(a_last_op_done, (state_q == ST_WB) && (op_q == OP_F1), state_q == ST_DONE, "last op did not finish")
  `DQTG_ASSERT_NEXT(a_result_posted, (state_q == ST_DONE) && (!out_valid_q || out_ready_i), out_valid_o && in_ready_o, "result not posted")

endmodule

// File: sim/tone_sample_checker.sv
`timescale 1ns / 1ps

// Watches the beat channels and the register port, runs its own copy of the
// oscillator for every accepted input beat and compares the sample stream.
module tone_sample_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              restart_i,
  input  logic                              mix_enable_i,
  input  logic signed [dqtg_pkg::DataW-1:0] mix_sample_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [dqtg_pkg::DataW-1:0] sample_i,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [dqtg_pkg::DataW-1:0]        cfg_wdata_i,
  output int                                mismatch_count_o,
  output int                                samples_pending_o,
  output int                                samples_checked_o
);
  import dqtg_pkg::*;

  localparam longint      PCT1_Q32   = 42949673;     // 0.01
  localparam longint      DAMP_Q30   = 1063004406;   // 0.99
  localparam longint      BOOST_Q30  = 1084479242;   // 1.01
  localparam longint      HALF_Q32   = 64'sd2147483648;
  localparam longint      ONE_Q32    = 64'sd4294967296;
  localparam logic [31:0] LCG_FACTOR = 32'd16807;
  localparam int          MAX_REPORTS = 10;

  logic [31:0]        phase_step, drift_frac, volume;
  logic signed [31:0] noise_gain, start_detune;
  logic signed [31:0] osc_pos, osc_vel, freq_fac, energy;
  logic [31:0]        noise_seed;
  logic signed [31:0] expected_samples[$];

  // floor(x / 2^sh), rounded half up
  function automatic longint round_shift(input longint x, input int unsigned sh);
    return (x >>> sh) + ((x >>> (sh - 1)) & 64'sd1);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic longint zext(input logic [31:0] v);
    return longint'({32'd0, v});
  endfunction

  function automatic void reload_osc();
    osc_pos    = '0;
    osc_vel    = clamp32(round_shift(zext(volume) * PCT1_Q32, 28));
    freq_fac   = clamp32(round_shift(zext(phase_step) * longint'(start_detune), 30));
    energy     = '0;
    noise_seed = SEED_INIT;
  endfunction

  function automatic logic signed [31:0] step_tone(input logic restart,
                                                    input logic mix_en,
                                                    input logic signed [31:0] mix);
    logic [63:0]        pd;
    longint             drift_term, jitter_coeff, keep, acc, rnd, ff;
    logic signed [31:0] noise_drift, smp;
    if (restart) reload_osc();

    pd           = zext(phase_step) * zext(drift_frac);
    drift_term   = longint'(pd >> 38) + longint'((pd >> 37) & 64'd1);
    noise_drift  = clamp32(round_shift(longint'(noise_gain) * zext(drift_frac), 32));
    jitter_coeff = clamp32(round_shift(zext(phase_step) * longint'(noise_drift), 30));
    keep         = ONE_Q32 - zext(drift_frac);

    ff      = freq_fac;
    osc_pos = clamp32(longint'(osc_pos) + round_shift(longint'(osc_vel) * ff, 24));
    smp     = mix_en ? clamp32(longint'(mix) + longint'(osc_pos)) : osc_pos;
    osc_vel = clamp32(longint'(osc_vel) - round_shift(longint'(osc_pos) * ff, 24));

    noise_seed = noise_seed * LCG_FACTOR;
    rnd        = zext(noise_seed);

    // amplitude regulation against a noisy threshold in [0.5, 1.5)
    if (longint'(energy) * 256 > rnd + HALF_Q32)
      osc_vel = clamp32(round_shift(longint'(osc_vel) * DAMP_Q30, 30));
    else
      osc_vel = clamp32(round_shift(longint'(osc_vel) * BOOST_Q30, 30));

    acc = round_shift(longint'(energy) * DAMP_Q30, 30)
        + round_shift(longint'(osc_pos) * longint'(osc_pos), 32)
        + round_shift(longint'(osc_vel) * longint'(osc_vel), 32);
    energy = clamp32(acc);

    acc = round_shift(ff * keep, 32) + drift_term + round_shift(rnd * jitter_coeff, 32);
    freq_fac = clamp32(acc);
    return smp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] want;
    if (!rst_ni) begin
      phase_step   = PHASE_STEP_RST;
      drift_frac   = DRIFT_FRAC_RST;
      noise_gain   = NOISE_GAIN_RST;
      start_detune = START_DETUNE_RST;
      volume       = VOLUME_RST;
      reload_osc();
      expected_samples.delete();
      mismatch_count_o  = 0;
      samples_pending_o = 0;
      samples_checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PHASE_STEP:   phase_step   = cfg_wdata_i;
          CFG_DRIFT_FRAC:   drift_frac   = cfg_wdata_i;
          CFG_NOISE_GAIN:   noise_gain   = cfg_wdata_i;
          CFG_START_DETUNE: start_detune = cfg_wdata_i;
          CFG_VOLUME:       volume       = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= MAX_REPORTS)
            $display("unexpected sample beat: got %h", sample_i);
        end else begin
          want = expected_samples.pop_front();
          if (sample_i !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= MAX_REPORTS)
              $display("sample beat %0d: expected %h, got %h",
                       samples_checked_o, want, sample_i);
          end
          samples_checked_o++;
        end
      end
      if (in_valid_i && in_ready_i)
        expected_samples.push_back(step_tone(restart_i, mix_enable_i, mix_sample_i));
      samples_pending_o = expected_samples.size();
    end
  end

endmodule

// File: sim/tb_drifting_quadrature_tone_generator_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the tone generator. The checker beside the DUT does
// all prediction and comparison; this module drives beats and register writes.
module tb_drifting_quadrature_tone_generator_top;
  import dqtg_pkg::*;

  localparam int DRAIN_CYCLES  = 40;   // restart latency plus margin
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS   = 60;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    restart_i;
  logic                    mix_enable_i;
  logic signed [DataW-1:0] mix_sample_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [DataW-1:0] sample_o;
  logic                    cfg_we_i;
  logic [2:0]              cfg_idx_i;
  logic [DataW-1:0]        cfg_wdata_i;

  int mismatches, pending, checked;
  int send_idle_pct, recv_idle_pct;
  int beats_sent, restarts_sent, settings_used;

  drifting_quadrature_tone_generator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .mix_enable_i (mix_enable_i),
    .mix_sample_i (mix_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  tone_sample_checker sample_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .restart_i         (restart_i),
    .mix_enable_i      (mix_enable_i),
    .mix_sample_i      (mix_sample_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sample_i          (sample_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mismatch_count_o  (mismatches),
    .samples_pending_o (pending),
    .samples_checked_o (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #10_000_000;
    $display("timeout: %0d beats sent, %0d samples checked", beats_sent, checked);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: ready drops at random per the current idle share.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // One register write per clock; the caller lowers the enable when done.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Only called with the DUT idle. New values reach the oscillator state at
  // the next restart; the drift terms pick them up at once.
  task automatic load_settings(input logic [31:0] phase, input logic [31:0] drift,
                               input logic [31:0] noise, input logic [31:0] detune,
                               input logic [31:0] vol);
    cfg_write(CFG_PHASE_STEP, phase);
    cfg_write(CFG_DRIFT_FRAC, drift);
    cfg_write(CFG_NOISE_GAIN, noise);
    cfg_write(CFG_START_DETUNE, detune);
    cfg_write(CFG_VOLUME, vol);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Writes to indexes past the register list must not land anywhere.
  task automatic poke_unused_indexes();
    for (int idx = CFG_VOLUME + 1; idx < 8; idx++)
      cfg_write(3'(idx), $urandom());
  endtask

  // Valid is held (never dropped and re-raised in one step) between
  // back-to-back beats; an idle gap lowers it first.
  task automatic send_beat(input logic restart, input logic mix_en,
                           input logic [31:0] mix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    restart_i    <= restart;
    mix_enable_i <= mix_en;
    mix_sample_i <= mix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
    if (restart) restarts_sent++;
  endtask

  // Wait out every expected sample, then the pipeline tail, before touching
  // the registers again.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_beat(input logic force_restart);
    logic [31:0] mix;
    case ($urandom_range(0, 9))
      0:       mix = 32'h7FFF_FFFF;
      1:       mix = 32'h8000_0000;
      2:       mix = $urandom_range(0, 255) - 128;
      default: mix = $urandom();
    endcase
    send_beat(force_restart || ($urandom_range(0, 99) < 4), 1'($urandom_range(0, 1)), mix);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    restart_i     <= 1'b0;
    mix_enable_i  <= 1'b0;
    mix_sample_i  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_PHASE_STEP;
    cfg_wdata_i   <= '0;
    send_idle_pct = 37;
    recv_idle_pct = 70;
    beats_sent    = 0;
    restarts_sent = 0;
    settings_used = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // reset registers: zero frequency, so the mix path shows at its extremes
    send_beat(1'b0, 1'b0, 32'h7FFF_FFFF);
    send_beat(1'b0, 1'b1, 32'h7FFF_FFFF);
    send_beat(1'b0, 1'b1, 32'h8000_0000);
    send_beat(1'b1, 1'b0, 32'h0000_0000);
    drain();

    // every register at its top: position and mixed sum saturate
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF);
    send_beat(1'b1, 1'b1, 32'h7FFF_FFFF);
    send_beat(1'b0, 1'b1, 32'h8000_0000);
    send_beat(1'b0, 1'b1, 32'h7FFF_FFFF);
    send_beat(1'b0, 1'b0, 32'h8000_0000);
    send_beat(1'b0, 1'b1, 32'h8000_0000);
    send_beat(1'b0, 1'b1, 32'h7FFF_FFFF);
    drain();

    // every register at its bottom, with stray writes to unused indexes
    poke_unused_indexes();
    load_settings(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h0000_0000);
    send_beat(1'b1, 1'b0, 32'h0000_0000);
    send_beat(1'b0, 1'b1, 32'h8000_0000);
    send_beat(1'b0, 1'b1, 32'hFFFF_FFFF);
    send_beat(1'b0, 1'b0, 32'h7FFF_FFFF);
    drain();

    // a plain tone (0.2 rad, volume 100, negative jitter), restarted midway
    load_settings(32'd214748365, 32'h0100_0000, 32'hFF00_0000, 32'h0100_0000,
                  32'd1677721600);
    for (int i = 0; i < 8; i++)
      send_beat(i == 0 || i == 4, i[0], $urandom());
    drain();

    // --- random phases ---
    // Mostly musical settings with long unbroken runs so the energy loop and
    // drift settle; every third phase takes fully random registers.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph / 4)
        0: begin send_idle_pct = 37; recv_idle_pct = 70; end
        1: begin send_idle_pct = 70; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph % 3 == 2) begin
        poke_unused_indexes();
        load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        load_settings($urandom_range(0, 32'd1 << 30),
                      ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 32'd1 << 28),
                      $urandom_range(0, 32'd1 << 27) - (32'd1 << 26),
                      $urandom_range(32'd1 << 23, 32'd3 << 23),
                      $urandom_range(0, 32'd3_355_443_200));
      end
      for (int i = 0; i < PHASE_BEATS; i++)
        random_beat(i == 0);
      drain();
    end

    $display("covered %0d input beats (%0d restarts) over %0d register settings",
             beats_sent, restarts_sent, settings_used);
    $display("%0d samples compared, %0d mismatches, %0d still expected",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
